FILE: rtl/core/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared constants and types for the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

	localparam int WINDOW_DEF = 8;

	// fixed field widths
	localparam int CMD_W   = 2;
	localparam int SEQ_IN_W = 4;
	localparam int ACT_W   = 3;
	localparam int FSEQ_W  = 4;
	localparam int INFL_W  = 4;
	localparam int TMR_W   = 8;

	localparam logic [TMR_W-1:0] TIMEOUT_RST = 8'd10;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_NACK = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd3;

	// result action codes
	localparam logic [ACT_W-1:0] ACT_TX_NEW   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_TO_RETX  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_NK_RETX  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_FULL     = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DONE     = 3'd4;
	localparam logic [ACT_W-1:0] ACT_IDLE     = 3'd5;

	// controller -> datapath
	typedef struct packed {
		logic accept;     // item taken this cycle
		logic ack_step;   // free the base slot
		logic ack_end;    // emit ack done
		logic tick_issue; // read next timer of the scan
		logic tick_end;   // emit final tick result
	} srsw_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic ack_more;   // ack seq still inside outstanding range
		logic scan_last;  // scan read address at the last slot
	} srsw_sts_t;

endpackage

FILE: rtl/core/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender-side window control for selective-repeat ARQ, sequence numbers
// modulo 2*WINDOW.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+---------------------
//  item in  | cmd, seq                                  | start && !busy
//  result   | action, frame_seq, in_flight, last        | result_valid, 1 cyc
//  config   | psel, penable, pwrite, paddr, pwdata, ... | APB, pready tied 1
//
//  Send and nack do not leave idle; result the cycle after accept.
//  An ack walks the released slots one per cycle.
//  A tick scans the timer memory one slot a cycle through its single read
//  port plus a registered read, with results spread over the scan.
//  Reset: async, clears pointers, count and slot flags; timers are written
//  on send before they are ever used. The receiver cannot stall results.
//
module selective_repeat_sender_window import srsw_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// item in
	input  logic                start,
	output logic                busy,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [SEQ_IN_W-1:0] seq,
	// results
	output logic                result_valid,
	output logic [ACT_W-1:0]    action,
	output logic [FSEQ_W-1:0]   frame_seq,
	output logic [INFL_W-1:0]   in_flight,
	output logic                last,
	// config
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// register 0 at byte 0; bit 2 set means beyond the register list
	localparam logic REG_TIMEOUT = 1'b0;

	logic [TMR_W-1:0] timeout_q;
	srsw_ctl_t        ctl;
	srsw_sts_t        sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? 32'(timeout_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
			timeout_q <= pwdata[TMR_W-1:0];
		end
	end

	srsw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl)
	);

	srsw_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.seq           (seq),
		.timeout_ticks (timeout_q),
		.ctl           (ctl),
		.sts           (sts),
		.result_valid  (result_valid),
		.action        (action),
		.frame_seq     (frame_seq),
		.in_flight     (in_flight),
		.last          (last)
	);

endmodule

FILE: rtl/core/srsw_ctrl.sv
// ----------------------------------------------------------------------------
// srsw_ctrl
// Sequencer: send/nack handled in idle, ack release walk, tick timer scan.
// ----------------------------------------------------------------------------
module srsw_ctrl import srsw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CMD_W-1:0] cmd,
	input  srsw_sts_t        sts,
	output logic             busy,
	output srsw_ctl_t        ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACK,
		S_TICK,
		S_DRAIN,
		S_FINAL
	} state_t;

	state_t state_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl            = '0;
		ctl.accept     = start && (state_q == S_IDLE);
		ctl.ack_step   = (state_q == S_ACK) && sts.ack_more;
		ctl.ack_end    = (state_q == S_ACK) && !sts.ack_more;
		ctl.tick_issue = (state_q == S_TICK);
		ctl.tick_end   = (state_q == S_FINAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start && cmd == CMD_ACK) begin
						state_q <= S_ACK;
					end else if (start && cmd == CMD_TICK) begin
						state_q <= S_TICK;
					end
				end
				S_ACK: begin
					if (!sts.ack_more) state_q <= S_IDLE;
				end
				S_TICK: begin
					if (sts.scan_last) state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_FINAL;
				S_FINAL: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/srsw_dp.sv
// ----------------------------------------------------------------------------
// srsw_dp
// Window pointers, slot flags, timer memory, timer scan and result register.
// ----------------------------------------------------------------------------
module srsw_dp import srsw_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [SEQ_IN_W-1:0] seq,
	input  logic [TMR_W-1:0]    timeout_ticks,
	input  srsw_ctl_t           ctl,
	output srsw_sts_t           sts,
	output logic                result_valid,
	output logic [ACT_W-1:0]    action,
	output logic [FSEQ_W-1:0]   frame_seq,
	output logic [INFL_W-1:0]   in_flight,
	output logic                last
);

	localparam int SEQ_MOD = 2 * WINDOW;
	localparam int SEQ_W   = $clog2(SEQ_MOD);
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int XW      = (SEQ_W > SEQ_IN_W) ? SEQ_W : SEQ_IN_W;

	localparam logic [SEQ_W-1:0] SEQ_TOP = SEQ_W'(SEQ_MOD - 1);
	localparam logic [XW:0]      SEQ_LIM = (XW+1)'(SEQ_MOD);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WINDOW);

	logic [SEQ_W-1:0]   base_q, next_q;
	logic [CNT_W-1:0]   outst_q;
	logic [SEQ_MOD-1:0] used_q;
	logic [TMR_W-1:0]   tmr_mem [SEQ_MOD];
	logic [XW-1:0]      ack_seq_q;

	logic [SEQ_W-1:0]   rd_idx_q;
	logic [SEQ_W-1:0]   proc_idx_s1;
	logic               proc_vld_s1;
	logic [TMR_W-1:0]   rdata_s1;
	logic               pend_vld_q;
	logic [SEQ_W-1:0]   pend_seq_q;

	function automatic logic in_win(input logic [SEQ_W-1:0] lo, input logic [XW-1:0] sx,
			input logic [SEQ_W-1:0] hi);
		logic             ok;
		logic [SEQ_W-1:0] s;
		ok = ({1'b0, sx} < SEQ_LIM);
		s  = sx[SEQ_W-1:0];
		return ok && ((lo <= s && s < hi) || (hi < lo && lo <= s) || (s < hi && hi < lo));
	endfunction

	function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
		return (s == SEQ_TOP) ? '0 : s + 1'b1;
	endfunction

	logic [XW-1:0] seq_x;
	logic          is_send, is_nack, is_tick, full, nack_hit;
	logic          proc_used, proc_fire;
	logic [TMR_W-1:0] t_dec;
	logic          mem_we;
	logic [SEQ_W-1:0] mem_wa;
	logic [TMR_W-1:0] mem_wd;
	logic          emit, e_last;
	logic [ACT_W-1:0] e_act;
	logic [SEQ_W-1:0] e_seq;
	logic [CNT_W-1:0] e_infl;

	assign seq_x    = XW'(seq);
	assign is_send  = ctl.accept && (cmd == CMD_SEND);
	assign is_nack  = ctl.accept && (cmd == CMD_NACK);
	assign is_tick  = ctl.accept && (cmd == CMD_TICK);
	assign full     = (outst_q == CNT_MAX);
	assign nack_hit = in_win(base_q, seq_x, next_q);

	assign sts.ack_more  = in_win(base_q, ack_seq_q, next_q);
	assign sts.scan_last = (rd_idx_q == SEQ_TOP);

	// scan stage: timer of proc_idx_s1 is in rdata_s1
	assign proc_used = proc_vld_s1 && used_q[proc_idx_s1];
	assign t_dec     = (rdata_s1 != '0) ? rdata_s1 - 1'b1 : '0;
	assign proc_fire = proc_used && (t_dec == '0);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = next_q;
		mem_wd = timeout_ticks;
		if (is_send && !full) begin
			mem_we = 1'b1;
		end else if (is_nack && nack_hit) begin
			mem_we = 1'b1;
			mem_wa = seq_x[SEQ_W-1:0];
		end else if (proc_used) begin
			mem_we = 1'b1;
			mem_wa = proc_idx_s1;
			mem_wd = proc_fire ? timeout_ticks : t_dec;
		end
	end

	always_comb begin
		emit   = 1'b0;
		e_act  = ACT_DONE;
		e_seq  = '0;
		e_last = 1'b1;
		e_infl = outst_q;
		if (is_send) begin
			emit = 1'b1;
			if (full) begin
				e_act = ACT_FULL;
			end else begin
				e_act  = ACT_TX_NEW;
				e_seq  = next_q;
				e_infl = outst_q + 1'b1;
			end
		end else if (is_nack) begin
			emit = 1'b1;
			if (nack_hit) begin
				e_act = ACT_NK_RETX;
				e_seq = seq_x[SEQ_W-1:0];
			end
		end else if (ctl.ack_end) begin
			emit = 1'b1;
		end else if (proc_fire && pend_vld_q) begin
			// a later firing slot exists, so the held one is not final
			emit   = 1'b1;
			e_act  = ACT_TO_RETX;
			e_seq  = pend_seq_q;
			e_last = 1'b0;
		end else if (ctl.tick_end) begin
			emit = 1'b1;
			if (pend_vld_q) begin
				e_act = ACT_TO_RETX;
				e_seq = pend_seq_q;
			end else begin
				e_act = ACT_IDLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) tmr_mem[mem_wa] <= mem_wd;
		rdata_s1 <= tmr_mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			next_q       <= '0;
			outst_q      <= '0;
			used_q       <= '0;
			proc_vld_s1  <= 1'b0;
			pend_vld_q   <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= emit;
			proc_vld_s1  <= ctl.tick_issue;
			if (is_send && !full) begin
				used_q[next_q] <= 1'b1;
				next_q         <= seq_inc(next_q);
				outst_q        <= outst_q + 1'b1;
			end
			if (ctl.ack_step) begin
				used_q[base_q] <= 1'b0;
				base_q         <= seq_inc(base_q);
				outst_q        <= outst_q - 1'b1;
			end
			if (is_tick || ctl.tick_end) begin
				pend_vld_q <= 1'b0;
			end else if (proc_fire) begin
				pend_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) ack_seq_q <= seq_x;
		if (is_tick) begin
			rd_idx_q <= '0;
		end else if (ctl.tick_issue) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
		proc_idx_s1 <= rd_idx_q;
		if (proc_fire) pend_seq_q <= proc_idx_s1;
		action    <= e_act;
		frame_seq <= FSEQ_W'(e_seq);
		in_flight <= INFL_W'(e_infl);
		last      <= e_last;
	end

endmodule

FILE: rtl/core/srsw_checker.sv
// ----------------------------------------------------------------------------
// srsw_checker
// Port-level checks for the sender window, bound to the top level.
// ----------------------------------------------------------------------------
module srsw_checker import srsw_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [CMD_W-1:0]  cmd,
	input logic              result_valid,
	input logic [ACT_W-1:0]  action,
	input logic [INFL_W-1:0] in_flight,
	input logic              last
);

	// never more frames outstanding than the window
	a_infl_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (32'(in_flight) <= WINDOW))
		else $error("in_flight above window");

	// send and nack answer in the next cycle with a single final result
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_SEND || cmd == CMD_NACK))
		|=> (result_valid && last))
		else $error("send/nack result missing");

	// a non-final result only shows while the item is still in progress
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |-> busy)
		else $error("item ended on a non-final result");

	// a new transmit always leaves at least one frame in flight
	a_tx_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && action == ACT_TX_NEW) |-> (in_flight != '0))
		else $error("transmit with nothing in flight");

endmodule

bind selective_repeat_sender_window srsw_checker #(.WINDOW(WINDOW)) u_chk (.*);
